### design/dpcm4_pkg.sv
// Shared types and constants for the 4-bit DPCM audio stream decoder.
package dpcm4_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam logic [3:0]  HDR_LAST_POS = 4'd11;
  localparam logic [7:0]  MAGIC_0 = 8'h56;  // 'V'
  localparam logic [7:0]  MAGIC_1 = 8'h44;  // 'D'
  localparam logic [7:0]  MAGIC_2 = 8'h31;  // '1'
  localparam logic [7:0]  MAGIC_3 = 8'h00;

  typedef enum logic [2:0] {
    ST_SAMPLE = 3'd0,
    ST_DONE   = 3'd1,
    ST_SHORT  = 3'd2,
    ST_MAGIC  = 3'd3,
    ST_COUNT  = 3'd4,
    ST_TRUNC  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  sample;
    logic [23:0] sample_count;
  } item_t;

  // Up to three results caused by one input byte, slot 0 first.
  typedef struct packed {
    logic [1:0]                   n;
    item_t [MAX_RESULTS-1:0]      items;
  } bundle_t;

endpackage

### design/dpcm4_core.sv
// Frame parser and DPCM predictor: turns one accepted byte into a result bundle.
module dpcm4_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic                end_of_source,
  input  logic                cfg_wr_en,
  input  logic [23:0]         cfg_wr_data,
  output dpcm4_pkg::bundle_t  bundle
);
  import dpcm4_pkg::*;

  logic [3:0]  hdr_pos_r, hdr_pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic        magic_good_r, magic_good_nxt;
  logic [31:0] count_r, count_nxt;
  logic [7:0]  step_r, step_nxt;
  logic [7:0]  pred_r, pred_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [23:0] max_samples_r;

  logic [7:0]  magic_byte;
  logic [7:0]  pred_hi, pred_lo;
  logic [1:0]  k;

  // Add one signed delta times the step to the predictor, clamp to 0..255.
  function automatic logic [7:0] apply_delta(input logic [7:0] pred,
                                             input logic [3:0] nib,
                                             input logic [7:0] step);
    logic signed [12:0] prod;
    logic signed [12:0] sum;
    prod = 13'(signed'(nib)) * signed'({5'b0, step});
    sum  = prod + signed'({5'b0, pred});
    if (sum < 13'sd0) begin
      apply_delta = 8'd0;
    end else if (sum > 13'sd255) begin
      apply_delta = 8'd255;
    end else begin
      apply_delta = sum[7:0];
    end
  endfunction

  always_comb begin
    case (hdr_pos_r[1:0])
      2'd0:    magic_byte = MAGIC_0;
      2'd1:    magic_byte = MAGIC_1;
      2'd2:    magic_byte = MAGIC_2;
      default: magic_byte = MAGIC_3;
    endcase
  end

  // Both nibbles of a body byte, high nibble first.
  assign pred_hi = apply_delta(pred_r, data_byte[7:4], step_r);
  assign pred_lo = apply_delta(pred_hi, data_byte[3:0], step_r);

  // Next state and results for the byte on the input.
  always_comb begin
    hdr_pos_nxt    = hdr_pos_r;
    phase_nxt      = phase_r;
    magic_good_nxt = magic_good_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    pred_nxt       = pred_r;
    remain_nxt     = remain_r;
    bundle         = '0;
    k              = 2'd0;

    case (phase_r)
      PH_HEADER: begin
        // Collect header fields
        if (hdr_pos_r < 4'd4) begin
          if (data_byte != magic_byte) magic_good_nxt = 1'b0;
        end else if (hdr_pos_r < 4'd8) begin
          count_nxt[8*hdr_pos_r[1:0] +: 8] = data_byte;
        end else if (hdr_pos_r == 4'd8) begin
          pred_nxt = data_byte;
        end else if (hdr_pos_r == 4'd9) begin
          step_nxt = (data_byte != 8'd0) ? data_byte : 8'd1;
        end

        if (hdr_pos_r >= HDR_LAST_POS) begin
          // Judge header: magic, then count
          if (!magic_good_r) begin
            bundle.items[k] = '{ST_MAGIC, 8'd0, 24'd0};
            k = k + 2'd1;
            phase_nxt = PH_SKIP;
          end else if (count_r == 32'd0 || count_r > {8'd0, max_samples_r}) begin
            bundle.items[k] = '{ST_COUNT, 8'd0, 24'd0};
            k = k + 2'd1;
            phase_nxt = PH_SKIP;
          end else begin
            bundle.items[k] = '{ST_SAMPLE, pred_r, 24'd0};
            k = k + 2'd1;
            remain_nxt = count_r - 32'd1;
            if (count_r == 32'd1) begin
              bundle.items[k] = '{ST_DONE, 8'd0, count_r[23:0]};
              k = k + 2'd1;
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_BODY;
              if (end_of_source) begin
                bundle.items[k] = '{ST_TRUNC, 8'd0, 24'd0};
                k = k + 2'd1;
              end
            end
          end
        end else if (end_of_source) begin
          bundle.items[k] = '{ST_SHORT, 8'd0, 24'd0};
          k = k + 2'd1;
        end else begin
          hdr_pos_nxt = hdr_pos_r + 4'd1;
        end
      end

      PH_BODY: begin
        // Emit up to two samples, then done or truncation
        if (remain_nxt != 32'd0) begin
          bundle.items[k] = '{ST_SAMPLE, pred_hi, 24'd0};
          k = k + 2'd1;
          pred_nxt   = pred_hi;
          remain_nxt = remain_nxt - 32'd1;
        end
        if (remain_nxt != 32'd0) begin
          bundle.items[k] = '{ST_SAMPLE, pred_lo, 24'd0};
          k = k + 2'd1;
          pred_nxt   = pred_lo;
          remain_nxt = remain_nxt - 32'd1;
        end
        if (remain_nxt == 32'd0) begin
          bundle.items[k] = '{ST_DONE, 8'd0, count_r[23:0]};
          k = k + 2'd1;
          phase_nxt = PH_SKIP;
        end else if (end_of_source) begin
          bundle.items[k] = '{ST_TRUNC, 8'd0, 24'd0};
          k = k + 2'd1;
        end
      end

      default: begin
        // Skip phase: drop bytes until the end flag
      end
    endcase

    // End flag restarts header parsing
    if (end_of_source) begin
      hdr_pos_nxt    = 4'd0;
      phase_nxt      = PH_HEADER;
      magic_good_nxt = 1'b1;
      count_nxt      = 32'd0;
      step_nxt       = 8'd1;
      pred_nxt       = 8'd0;
      remain_nxt     = 32'd0;
    end

    bundle.n = k;
  end

  // Advance frame state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r    <= 4'd0;
      phase_r      <= PH_HEADER;
      magic_good_r <= 1'b1;
      count_r      <= 32'd0;
      step_r       <= 8'd1;
      pred_r       <= 8'd0;
      remain_r     <= 32'd0;
    end else if (in_fire) begin
      hdr_pos_r    <= hdr_pos_nxt;
      phase_r      <= phase_nxt;
      magic_good_r <= magic_good_nxt;
      count_r      <= count_nxt;
      step_r       <= step_nxt;
      pred_r       <= pred_nxt;
      remain_r     <= remain_nxt;
    end
  end

  // Hold capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_samples_r <= 24'hFF_FFFF;
    end else if (cfg_wr_en) begin
      max_samples_r <= cfg_wr_data;
    end
  end

  a_body_has_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> remain_r != 32'd0)
    else $error("body phase with no samples remaining");

  a_hdr_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pos_r <= HDR_LAST_POS)
    else $error("header position ran past the final header byte");

  a_eos_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && end_of_source |=> phase_r == PH_HEADER && hdr_pos_r == 4'd0)
    else $error("end flag did not restart header parsing");

endmodule

### design/dpcm4_oser.sv
// Result buffer: holds one pending bundle and serializes the active one.
module dpcm4_oser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dpcm4_pkg::bundle_t  bundle,
  output logic                pend_free,
  output logic                out_valid,
  input  logic                out_ready,
  output dpcm4_pkg::item_t    out_item,
  output logic                out_last
);
  import dpcm4_pkg::*;

  logic    pend_valid_r, pend_valid_nxt;
  bundle_t pend_r;
  logic    act_valid_r, act_valid_nxt;
  bundle_t act_r;
  logic [1:0] idx_r, idx_nxt;
  logic    out_fire, act_final, act_load;

  assign out_fire  = act_valid_r && out_ready;
  assign act_final = (idx_r == act_r.n - 2'd1);
  assign act_load  = pend_valid_r && (!act_valid_r || (out_fire && act_final));
  assign pend_free = !pend_valid_r || act_load;

  assign out_valid = act_valid_r;
  assign out_item  = act_r.items[idx_r];
  assign out_last  = act_final;

  // Next state of both slots
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    act_valid_nxt  = act_valid_r;
    idx_nxt        = idx_r;
    if (push) begin
      pend_valid_nxt = 1'b1;
    end else if (act_load) begin
      pend_valid_nxt = 1'b0;
    end
    if (act_load) begin
      act_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (out_fire) begin
      if (act_final) begin
        act_valid_nxt = 1'b0;
      end
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      act_valid_r  <= 1'b0;
      idx_r        <= 2'd0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      act_valid_r  <= act_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      pend_r <= bundle;
    end
    if (act_load) begin
      act_r <= pend_r;
    end
  end

  a_act_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    act_valid_r |-> act_r.n != 2'd0)
    else $error("active bundle holds no results");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_valid_r |-> idx_r < act_r.n)
    else $error("result index past end of bundle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !pend_valid_r || act_load)
    else $error("pending bundle overwritten");

endmodule

### design/dpcm4_audio_stream_decoder.sv
// Top level of the 4-bit DPCM audio stream decoder.
//
// Input stream: one byte of the encoded clip per request, tlast on the final
// byte of the buffer. Result stream: one result per request (sample, done or
// an error status), tlast on the final result caused by one input byte.
// cfg_wr_en/cfg_wr_data load the capacity register; write it only while idle.
//
// The results of a byte are registered into the pending slot when the byte is
// accepted, and move on to the output slot once that slot is free.
// The result port moves one result per cycle while out_tready is high; a body
// byte carries up to two samples and a byte that ends a frame up to three
// results, while skipped bytes give none. A new byte is taken while the
// previous byte's results still drain from the output slot.
// Reset clears the frame parser to the start of a header, sets the capacity
// to its maximum and empties both result slots. When the receiver stalls,
// the output holds its result and, once the pending slot is full too,
// in_tready falls until room frees up.
module dpcm4_audio_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // end_of_source
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [2:0] status, [10:3] sample,
                                   // [34:11] sample_count, [39:35] zero
  output logic        out_tlast,   // last
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);
  import dpcm4_pkg::*;

  logic    in_fire;
  logic    pend_free;
  bundle_t bundle;
  item_t   out_item;

  assign in_tready = pend_free;
  assign in_fire   = in_tvalid && pend_free;

  dpcm4_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .data_byte     (in_tdata),
    .end_of_source (in_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .bundle        (bundle)
  );

  dpcm4_oser u_oser (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && (bundle.n != 2'd0)),
    .bundle    (bundle),
    .pend_free (pend_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item),
    .out_last  (out_tlast)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {5'd0, out_item.sample_count, out_item.sample, out_item.status};

endmodule

### sim/tb_top.sv
// Testbench for the 4-bit DPCM audio stream decoder: directed and random clips, scored results.
`timescale 1ns / 1ps

module tb_top;
  import dpcm4_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } clip_byte_t;

  typedef struct {
    status_t     status;
    logic [7:0]  sample;
    logic [23:0] count;
    logic        last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] data_byte
  logic        in_tlast = 1'b0;   // end_of_source
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [2:0] status, [10:3] sample, [34:11] sample_count
  logic        out_tlast;         // last
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;

  dpcm4_audio_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes waiting to be offered, bytes of the clip under construction, decoded results awaited
  clip_byte_t clip_q[$];
  logic [7:0] clip_bytes[$];
  decoded_t   decoded_q[$];
  int         fail_count = 0;
  int         results_seen = 0;

  // Decoder state mirror
  logic [7:0]  magic_bytes[4];
  logic [23:0] capacity;
  logic [3:0]  hdr_pos;
  phase_t      phase;
  logic        magic_ok;
  logic [31:0] hdr_count;
  logic [7:0]  step;
  logic [7:0]  level;
  logic [31:0] remaining;

  function automatic void restart_frame();
    hdr_pos   = '0;
    phase     = PH_HEADER;
    magic_ok  = 1'b1;
    hdr_count = '0;
    step      = 8'd1;
    level     = '0;
    remaining = '0;
  endfunction

  function automatic void push_result(status_t st, logic [7:0] smp, logic [23:0] cnt);
    decoded_t r;
    r.status = st;
    r.sample = smp;
    r.count  = cnt;
    r.last   = 1'b0;
    decoded_q.push_back(r);
  endfunction

  // Add one signed delta times the step to the level, clamped to 0..255
  function automatic logic [7:0] next_level(logic [3:0] nib);
    int q;
    int acc;
    q = int'(nib);
    if (q >= 8) q -= 16;
    acc = int'(level) + q * int'(step);
    if (acc < 0) acc = 0;
    else if (acc > 255) acc = 255;
    level = acc[7:0];
    return level;
  endfunction

  // Predict every result caused by one accepted clip byte
  function automatic void decode_byte(logic [7:0] data, logic eos);
    int size_at_entry;
    int k;
    logic [3:0] nib;
    size_at_entry = decoded_q.size();
    if (phase == PH_HEADER) begin
      if (hdr_pos < 4'd4) begin
        if (data != magic_bytes[hdr_pos[1:0]]) magic_ok = 1'b0;
      end else if (hdr_pos < 4'd8) begin
        hdr_count = hdr_count | (32'(data) << (8 * (hdr_pos - 4'd4)));
      end else if (hdr_pos == 4'd8) begin
        level = data;
      end else if (hdr_pos == 4'd9) begin
        step = (data == 8'd0) ? 8'd1 : data;
      end
      if (hdr_pos >= HDR_LAST_POS) begin
        if (!magic_ok) begin
          push_result(ST_MAGIC, '0, '0);
          phase = PH_SKIP;
        end else if (hdr_count == 0 || hdr_count > {8'd0, capacity}) begin
          push_result(ST_COUNT, '0, '0);
          phase = PH_SKIP;
        end else begin
          push_result(ST_SAMPLE, level, '0);
          remaining = hdr_count - 1;
          if (remaining == 0) begin
            push_result(ST_DONE, '0, hdr_count[23:0]);
            phase = PH_SKIP;
          end else begin
            phase = PH_BODY;
            if (eos) push_result(ST_TRUNC, '0, '0);
          end
        end
      end else if (eos) begin
        push_result(ST_SHORT, '0, '0);
      end else begin
        hdr_pos = hdr_pos + 4'd1;
      end
    end else if (phase == PH_BODY) begin
      // high nibble first; a spare low nibble is dropped
      for (k = 0; k < 2; k++) begin
        if (remaining > 0) begin
          nib = (k == 0) ? data[7:4] : data[3:0];
          push_result(ST_SAMPLE, next_level(nib), '0);
          remaining--;
        end
      end
      if (remaining == 0) begin
        push_result(ST_DONE, '0, hdr_count[23:0]);
        phase = PH_SKIP;
      end else if (eos) begin
        push_result(ST_TRUNC, '0, '0);
      end
    end
    if (decoded_q.size() > size_at_entry) decoded_q[decoded_q.size() - 1].last = 1'b1;
    if (eos) restart_frame();
  endfunction

  initial begin
    magic_bytes[0] = MAGIC_0;
    magic_bytes[1] = MAGIC_1;
    magic_bytes[2] = MAGIC_2;
    magic_bytes[3] = MAGIC_3;
    capacity = 24'hFFFFFF;
    restart_frame();
  end

  // Sender: offer queued bytes in bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    clip_byte_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (clip_q.size() > 0) begin
          b = clip_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= b.data;
          in_tlast  <= b.last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void report_mismatch(string field, logic [39:0] want, logic [39:0] got);
    fail_count++;
    if (fail_count <= 20)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  // Receiver: score each result and stall on a rotating ready pattern
  logic [31:0] ready_pattern = '1;
  int          pattern_age = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result", '0, out_tdata);
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata[2:0] != want.status)
            report_mismatch("status", 40'(want.status), 40'(out_tdata[2:0]));
          if (out_tdata[10:3] != want.sample)
            report_mismatch("sample", 40'(want.sample), 40'(out_tdata[10:3]));
          if (out_tdata[34:11] != want.count)
            report_mismatch("sample_count", 40'(want.count), 40'(out_tdata[34:11]));
          if (out_tdata[39:35] != 5'd0)
            report_mismatch("padding", '0, 40'(out_tdata[39:35]));
          if (out_tlast != want.last)
            report_mismatch("last", 40'(want.last), 40'(out_tlast));
        end
      end
      // hold off once for a long stretch while bytes are still queued so the decoder backs up
      if (!long_hold_done && results_seen >= 2 && clip_q.size() >= 20) begin
        hold_left = 400;
        long_hold_done = 1'b1;
      end
      if (pattern_age == 0) begin
        pattern_age = 48;
        ready_pattern = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'd1);
      end
      pattern_age--;
      ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ready_pattern[0];
      end
    end
  end

  // Fill clip_bytes with a 12-byte header, optionally with one magic bit flipped
  task automatic build_header(input logic [31:0] count, input logic [7:0] first,
                              input logic [7:0] step_code, input bit good_magic);
    int bad_pos;
    int i;
    logic [7:0] b;
    clip_bytes.delete();
    bad_pos = good_magic ? -1 : $urandom_range(0, 3);
    for (i = 0; i < 12; i++) begin
      if (i < 4) b = magic_bytes[i];
      else if (i < 8) b = count[8 * (i - 4) +: 8];
      else if (i == 8) b = first;
      else if (i == 9) b = step_code;
      else b = 8'($urandom_range(0, 255));
      if (i == bad_pos) b = b ^ (8'd1 << $urandom_range(0, 7));
      clip_bytes.push_back(b);
    end
  endtask

  task automatic add_noise(input int n);
    repeat (n) clip_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic trim_clip(input int n);
    while (clip_bytes.size() > n) void'(clip_bytes.pop_back());
  endtask

  // Queue the built clip with the end flag on its final byte
  task automatic ship_clip();
    int i;
    clip_byte_t b;
    for (i = 0; i < clip_bytes.size(); i++) begin
      b.data = clip_bytes[i];
      b.last = (i == clip_bytes.size() - 1);
      clip_q.push_back(b);
    end
    clip_bytes.delete();
  endtask

  // Random clips, mostly well formed, until about n bytes are queued
  task automatic random_clips(input int n);
    int queued;
    int kind;
    int need;
    logic [31:0] count;
    queued = 0;
    while (queued < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 30);
        if (count > {8'd0, capacity}) count = {8'd0, capacity};
        build_header(count, 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)), 1'b1);
        need = count / 2;
        case ($urandom_range(0, 3))
          1: add_noise(need + $urandom_range(1, 3));
          2: add_noise((need > 0) ? $urandom_range(0, need - 1) : 0);
          default: add_noise(need);
        endcase
      end else if (kind == 6) begin
        build_header($urandom_range(1, 20), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'b0);
        add_noise($urandom_range(0, 3));
      end else if (kind == 7) begin
        case ($urandom_range(0, 2))
          0: count = 0;
          1: count = {8'd0, capacity} + 1;
          default: count = $urandom | 32'h8000_0000;
        endcase
        build_header(count, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
        add_noise($urandom_range(0, 3));
      end else if (kind == 8) begin
        build_header($urandom_range(1, 20), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'b1);
        trim_clip($urandom_range(1, 11));
      end else begin
        add_noise($urandom_range(1, 20));
      end
      queued += clip_bytes.size();
      ship_clip();
    end
  endtask

  // Wait until every byte is taken and every result is back, then let the pipeline settle
  task automatic drain_decoder();
    @(negedge clk);
    while (clip_q.size() != 0 || in_tvalid || decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [23:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = value;
    @(negedge clk);
  endtask

  // Reset and stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-sample clip at full scale
    build_header(32'd1, 8'hFF, 8'hFF, 1'b1);
    ship_clip();
    // clamp at both ends, odd delta count, bytes after done ignored
    build_header(32'd4, 8'h00, 8'hFF, 1'b1);
    clip_bytes.push_back(8'h7F);
    clip_bytes.push_back(8'h80);
    clip_bytes.push_back(8'h5A);
    ship_clip();
    // short headers of three bytes and of eleven, the longest
    build_header(32'd5, 8'h01, 8'h01, 1'b1);
    trim_clip(3);
    ship_clip();
    build_header(32'd3, 8'h01, 8'h01, 1'b1);
    trim_clip(11);
    ship_clip();
    // bad magic wins over a zero count; trailing bytes ignored
    build_header(32'd0, 8'h09, 8'h03, 1'b0);
    add_noise(2);
    ship_clip();
    // zero count, then count above capacity
    build_header(32'd0, 8'h09, 8'h03, 1'b1);
    ship_clip();
    build_header(32'h0100_0000, 8'h09, 8'h03, 1'b1);
    ship_clip();
    // truncated in the body and right at the end of the header
    build_header(32'd10, 8'h80, 8'h00, 1'b1);
    clip_bytes.push_back(8'h17);
    ship_clip();
    build_header(32'd3, 8'h40, 8'h02, 1'b1);
    ship_clip();
    drain_decoder();

    write_capacity(24'hFFFFFF);
    random_clips(10);
    drain_decoder();

    write_capacity(24'd0);
    random_clips(6);
    drain_decoder();

    write_capacity(24'($urandom_range(1, 6)));
    random_clips(10);
    drain_decoder();

    write_capacity(24'($urandom_range(7, 40)));
    random_clips(10);
    drain_decoder();

    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
design/dpcm4_pkg.sv
design/dpcm4_core.sv
design/dpcm4_oser.sv
design/dpcm4_audio_stream_decoder.sv
sim/tb_top.sv
